[sv/bba_pkg.sv]
`default_nettype none

package bba_pkg;

   localparam int WORD_BITS  = 32;
   localparam int WORD_POS_W = 5;
   localparam int CURSOR_W   = WORD_POS_W + 1;

   localparam logic [1:0] OP_ALLOC         = 2'd0;
   localparam logic [1:0] OP_ALLOC_INDEXED = 2'd1;
   localparam logic [1:0] OP_FREE          = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_NO_INDEX = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] block_count;
      logic [6:0] block_index;
   } req_type;

   typedef struct packed {
      logic [6:0] granted_block;
      logic       block_valid;
      logic       is_index_block;
      logic [1:0] status;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

[sv/bba_bitmap_mem.sv]
`default_nettype none

module bba_bitmap_mem import bba_pkg::*; #(
   parameter int DEPTH  = 4,
   parameter int ADDR_W = 2
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    addr,
   input  wire logic [WORD_BITS-1:0] wr_data,
   output logic      [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/bba_find_free.sv]
`default_nettype none

module bba_find_free import bba_pkg::*; (
   input  wire logic [WORD_BITS-1:0]  word,
   input  wire logic [CURSOR_W-1:0]   start,
   output logic                       found,
   output logic      [WORD_POS_W-1:0] bit_pos
);

   logic [WORD_BITS-1:0] cand;

   always_comb begin
      found   = 1'b0;
      bit_pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         cand[i] = !word[i] && (CURSOR_W'(i) >= start);
      end
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            found   = 1'b1;
            bit_pos = WORD_POS_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

[sv/block_bitmap_allocator_core.sv]
// First-fit block allocator over a used/free bitmap of POOL_SIZE blocks.
// Requests enter on req_valid/req_stall with req_data; results leave on
// rsp_valid/rsp_stall with rsp_data. An allocate returns one result per
// granted block (an indexed allocate leads with the index block), then a
// shortfall result if the pool ran dry; a free or a zero-count allocate
// returns one result. The bitmap sits in a memory of 32-bit words scanned
// by one shared find-first-free unit. The first result of an allocate or
// an in-range free reaches the output register through S_READ, S_LOAD and
// S_SCAN or S_FREE_WRITE; a zero-count allocate or an out-of-range free
// goes straight to S_FINAL. Each word an allocate crosses takes an empty
// scan, a write back, a read and a load; one that ends in a shortfall or
// finds no index block closes in S_FINAL. One request is in work at a time:
// req_stall stays high until the word holding its last grant is written
// back or its closing result is registered. After reset the bitmap is
// cleared one word per cycle, all ceil(POOL_SIZE/32) words, with req_stall
// high. A stalled rsp holds its result and freezes a scan that has found a
// free block until the result is taken.
`default_nettype none

module block_bitmap_allocator_core import bba_pkg::*; #(
   parameter int POOL_SIZE = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int NUM_WORDS   = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int TAIL_BITS   = POOL_SIZE - (NUM_WORDS - 1) * WORD_BITS;
   localparam logic [WORD_ADDR_W-1:0] LAST_WORD = WORD_ADDR_W'(NUM_WORDS - 1);
   localparam logic [WORD_BITS-1:0] TAIL_MASK = (TAIL_BITS >= WORD_BITS) ? '0 :
      ~((WORD_BITS'(1) << TAIL_BITS) - WORD_BITS'(1));

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_LOAD, S_SCAN, S_WRITE, S_FREE_WRITE, S_FINAL
   } state_type;

   state_type              state_ff, state_in, after_ff, after_in;
   logic [1:0]             op_ff, op_in;
   logic [5:0]             want_ff, want_in, got_ff, got_in;
   logic [6:0]             bidx_ff, bidx_in;
   logic                   idx_phase_ff, idx_phase_in;
   logic [WORD_ADDR_W-1:0] word_addr_ff, word_addr_in;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic [CURSOR_W-1:0]    pos_ff, pos_in;
   logic [1:0]             fin_status_ff, fin_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   mem_wr_en;
   logic [WORD_BITS-1:0]   mem_wr_data, mem_rd_data;
   logic                   found;
   logic [WORD_POS_W-1:0]  find_bit;
   logic                   out_free, is_last_word, done;
   logic [WORD_ADDR_W+WORD_POS_W-1:0] blk_full;
   logic [31:0]            blk_wide, req_bidx_wide;
   logic [WORD_BITS-1:0]   find_onehot, free_onehot;
   logic [5:0]             got_next;

   bba_bitmap_mem #(
      .DEPTH  (NUM_WORDS),
      .ADDR_W (WORD_ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .addr    (word_addr_ff),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   bba_find_free u_find (
      .word    (word_ff),
      .start   (pos_ff),
      .found   (found),
      .bit_pos (find_bit)
   );

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign is_last_word  = (word_addr_ff == LAST_WORD);
   assign blk_full      = {word_addr_ff, find_bit};
   assign blk_wide      = 32'(blk_full);
   assign req_bidx_wide = 32'(req_data.block_index);
   assign find_onehot   = WORD_BITS'(1) << find_bit;
   assign free_onehot   = WORD_BITS'(1) << bidx_ff[WORD_POS_W-1:0];
   assign got_next      = 6'(got_ff + 6'd1);

   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      op_in         = op_ff;
      want_in       = want_ff;
      got_in        = got_ff;
      bidx_in       = bidx_ff;
      idx_phase_in  = idx_phase_ff;
      word_addr_in  = word_addr_ff;
      word_in       = word_ff;
      pos_in        = pos_ff;
      fin_status_in = fin_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      mem_wr_en     = 1'b0;
      mem_wr_data   = word_ff;
      done          = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            if (is_last_word) begin
               word_addr_in = '0;
               state_in     = S_IDLE;
            end else begin
               word_addr_in = WORD_ADDR_W'(word_addr_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_data.operation;
               want_in       = req_data.block_count;
               bidx_in       = req_data.block_index;
               got_in        = '0;
               idx_phase_in  = (req_data.operation == OP_ALLOC_INDEXED);
               pos_in        = '0;
               word_addr_in  = '0;
               fin_status_in = STATUS_OK;
               case (req_data.operation)
                  OP_FREE: begin
                     if (req_bidx_wide < 32'(POOL_SIZE)) begin
                        word_addr_in = req_bidx_wide[WORD_POS_W +: WORD_ADDR_W];
                        state_in     = S_READ;
                     end else begin
                        state_in = S_FINAL;
                     end
                  end
                  OP_ALLOC: begin
                     state_in = (req_data.block_count == 6'd0) ? S_FINAL : S_READ;
                  end
                  OP_ALLOC_INDEXED: begin
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            word_in  = mem_rd_data | (is_last_word ? TAIL_MASK : '0);
            state_in = (op_ff == OP_FREE) ? S_FREE_WRITE : S_SCAN;
         end
         S_SCAN: begin
            if (!found) begin
               if (is_last_word) begin
                  fin_status_in = idx_phase_ff ? STATUS_NO_INDEX : STATUS_SHORT;
                  after_in      = S_FINAL;
               end else begin
                  after_in = S_READ;
               end
               state_in = S_WRITE;
            end else if (out_free) begin
               word_in = word_ff | find_onehot;
               pos_in  = CURSOR_W'(find_bit) + CURSOR_W'(1);
               if (idx_phase_ff) begin
                  idx_phase_in = 1'b0;
                  done         = (want_ff == 6'd0);
               end else begin
                  got_in = got_next;
                  done   = (got_next == want_ff);
               end
               rsp_valid_in          = 1'b1;
               rsp_in.granted_block  = blk_wide[6:0];
               rsp_in.block_valid    = 1'b1;
               rsp_in.is_index_block = idx_phase_ff;
               rsp_in.status         = STATUS_OK;
               rsp_in.last           = done;
               if (done) begin
                  after_in = S_IDLE;
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            mem_wr_en = 1'b1;
            if (after_ff == S_READ) begin
               word_addr_in = WORD_ADDR_W'(word_addr_ff + 1'b1);
               pos_in       = '0;
            end
            state_in = after_ff;
         end
         S_FREE_WRITE: begin
            if (out_free) begin
               mem_wr_en             = 1'b1;
               mem_wr_data           = word_ff & ~free_onehot;
               rsp_valid_in          = 1'b1;
               rsp_in.granted_block  = bidx_ff;
               rsp_in.block_valid    = 1'b1;
               rsp_in.is_index_block = 1'b0;
               rsp_in.status         = STATUS_OK;
               rsp_in.last           = 1'b1;
               state_in              = S_IDLE;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.granted_block  = '0;
               rsp_in.block_valid    = 1'b0;
               rsp_in.is_index_block = 1'b0;
               rsp_in.status         = fin_status_ff;
               rsp_in.last           = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         after_ff     <= S_IDLE;
         word_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         word_addr_ff <= word_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      want_ff       <= want_in;
      got_ff        <= got_in;
      bidx_ff       <= bidx_in;
      idx_phase_ff  <= idx_phase_in;
      word_ff       <= word_in;
      pos_ff        <= pos_in;
      fin_status_ff <= fin_status_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[dv/tb_block_bitmap_allocator_core.sv]
`default_nettype none

module tb_block_bitmap_allocator_core;
   import bba_pkg::*;

   localparam int POOL_BLOCKS     = 128;
   localparam int RANDOM_ITEMS    = 108;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER  = 40;
   localparam int DRAIN_CYCLES    = 100;
   localparam int CYCLE_LIMIT     = 400000;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type closing_rsp;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   bit [POOL_BLOCKS-1:0] block_used;
   rsp_type              request_results[$];
   rsp_type              expected_grants[$];
   directed_row_type     directed_plan[$];
   int                   mismatches = 0;
   int                   cycle_count = 0;
   bit                   sender_quiet = 1'b0;

   block_bitmap_allocator_core #(.POOL_SIZE(POOL_BLOCKS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type make_rsp(input int blk, input bit valid_bit,
                                        input bit index_bit, input logic [1:0] st,
                                        input bit last_bit);
      rsp_type r;
      r.granted_block  = blk[6:0];
      r.block_valid    = valid_bit;
      r.is_index_block = index_bit;
      r.status         = st;
      r.last           = last_bit;
      return r;
   endfunction

   function automatic int first_free(input int start);
      for (int i = start; i < POOL_BLOCKS; i++) begin
         if (!block_used[i]) return i;
      end
      return POOL_BLOCKS;
   endfunction

   function automatic void predict_request(input req_type r);
      int cursor;
      int got;
      int blk;
      cursor = 0;
      got    = 0;
      request_results.delete();
      case (r.operation)
         OP_FREE: begin
            block_used[r.block_index] = 1'b0;
            request_results.push_back(make_rsp(r.block_index, 1, 0, STATUS_OK, 1));
         end
         OP_ALLOC, OP_ALLOC_INDEXED: begin
            if (r.operation == OP_ALLOC_INDEXED) begin
               blk = first_free(0);
               if (blk >= POOL_BLOCKS) begin
                  request_results.push_back(make_rsp(0, 0, 0, STATUS_NO_INDEX, 1));
                  return;
               end
               block_used[blk] = 1'b1;
               request_results.push_back(make_rsp(blk, 1, 1, STATUS_OK,
                                                  r.block_count == 0));
               cursor = blk + 1;
               if (r.block_count == 0) return;
            end else if (r.block_count == 0) begin
               request_results.push_back(make_rsp(0, 0, 0, STATUS_OK, 1));
               return;
            end
            while (got < r.block_count) begin
               blk = first_free(cursor);
               if (blk >= POOL_BLOCKS) break;
               block_used[blk] = 1'b1;
               got++;
               request_results.push_back(make_rsp(blk, 1, 0, STATUS_OK,
                                                  got == r.block_count));
               cursor = blk + 1;
            end
            if (got < r.block_count)
               request_results.push_back(make_rsp(0, 0, 0, STATUS_SHORT, 1));
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(input logic [1:0] op, input int count, input int idx,
                                   input bit typed, input rsp_type closing_rsp);
      directed_row_type row;
      row.item.operation   = op;
      row.item.block_count = count[5:0];
      row.item.block_index = idx[6:0];
      row.typed            = typed;
      row.closing_rsp      = closing_rsp;
      directed_plan.push_back(row);
   endfunction

   function automatic int pick_used();
      int start;
      start = $urandom_range(0, POOL_BLOCKS - 1);
      for (int i = 0; i < POOL_BLOCKS; i++) begin
         if (block_used[(start + i) % POOL_BLOCKS]) return (start + i) % POOL_BLOCKS;
      end
      return start;
   endfunction

   function automatic req_type draw_request();
      req_type r;
      int      roll;
      int      free_cut;
      r.block_index = 7'($urandom_range(0, POOL_BLOCKS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 80) r.block_count = 6'($urandom_range(0, 6));
      else if (roll < 95) r.block_count = 6'($urandom_range(7, 31));
      else r.block_count = 6'($urandom_range(32, 63));
      free_cut = ($countones(block_used) > 96) ? 70 : 40;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         r.operation = OP_UNUSED;
      end else if (roll < free_cut) begin
         r.operation = OP_FREE;
         if ($urandom_range(0, 3) != 0) r.block_index = 7'(pick_used());
      end else if (roll < free_cut + (100 - free_cut) / 3) begin
         r.operation = OP_ALLOC_INDEXED;
      end else begin
         r.operation = OP_ALLOC;
      end
      return r;
   endfunction

   task automatic send_request(input req_type item, input bit typed,
                               input rsp_type closing_rsp);
      int gap;
      if ($urandom_range(0, 11) == 0) sender_quiet = !sender_quiet;
      gap = sender_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_request(item);
      if (typed && request_results.size() != 0) begin
         void'(request_results.pop_back());
         request_results.push_back(closing_rsp);
      end
      foreach (request_results[i]) expected_grants.push_back(request_results[i]);
   endtask

   function automatic void check_grant(input rsp_type want, input rsp_type got);
      if (got.granted_block !== want.granted_block) begin
         $error("granted_block: expected %0d, actual %0d", want.granted_block,
                got.granted_block);
         mismatches++;
      end
      if (got.block_valid !== want.block_valid) begin
         $error("block_valid: expected %0d, actual %0d", want.block_valid,
                got.block_valid);
         mismatches++;
      end
      if (got.is_index_block !== want.is_index_block) begin
         $error("is_index_block: expected %0d, actual %0d", want.is_index_block,
                got.is_index_block);
         mismatches++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         mismatches++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, got.last);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_grants.size() == 0) begin
            $error("unexpected result: granted_block %0d status %0d",
                   rsp_data.granted_block, rsp_data.status);
            mismatches++;
         end else begin
            want = expected_grants.pop_front();
            check_grant(want, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("block_bitmap_allocator_core: mismatch");
         $finish;
      end
   end

   initial begin : result_receiver
      int  taken;
      int  hold;
      bit  quiet;
      bit  pressure_done;
      taken         = 0;
      quiet         = 1'b0;
      pressure_done = 1'b0;
      rsp_stall     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) quiet = !quiet;
         hold = quiet ? 0 : $urandom_range(0, 4);
         if (!pressure_done && taken >= HOLD_OFF_AFTER) begin
            hold          = HOLD_OFF_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : request_sender
      req_type item;
      int      random_sent;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;

      add_row(OP_ALLOC,         0,   0, 1, make_rsp(0,   0, 0, STATUS_OK,       1));
      add_row(OP_ALLOC,         1,   0, 1, make_rsp(0,   1, 0, STATUS_OK,       1));
      add_row(OP_ALLOC_INDEXED, 0,   0, 1, make_rsp(1,   1, 1, STATUS_OK,       1));
      add_row(OP_ALLOC_INDEXED, 3,   0, 0, '0);
      add_row(OP_FREE,          0,   3, 1, make_rsp(3,   1, 0, STATUS_OK,       1));
      add_row(OP_FREE,          0,   3, 1, make_rsp(3,   1, 0, STATUS_OK,       1));
      add_row(OP_ALLOC,         2,   0, 0, '0);
      add_row(OP_UNUSED,        63, 127, 0, '0);
      add_row(OP_FREE,          0, 127, 1, make_rsp(127, 1, 0, STATUS_OK,       1));
      add_row(OP_ALLOC,         63,  0, 0, '0);
      add_row(OP_ALLOC,         63,  0, 1, make_rsp(0,   0, 0, STATUS_SHORT,    1));
      add_row(OP_ALLOC_INDEXED, 5,   0, 1, make_rsp(0,   0, 0, STATUS_NO_INDEX, 1));
      add_row(OP_ALLOC,         1,   0, 1, make_rsp(0,   0, 0, STATUS_SHORT,    1));
      add_row(OP_ALLOC_INDEXED, 0,   0, 1, make_rsp(0,   0, 0, STATUS_NO_INDEX, 1));
      add_row(OP_FREE,          0,   0, 1, make_rsp(0,   1, 0, STATUS_OK,       1));
      add_row(OP_FREE,          0, 127, 1, make_rsp(127, 1, 0, STATUS_OK,       1));
      add_row(OP_ALLOC_INDEXED, 1,   0, 0, '0);
      add_row(OP_ALLOC_INDEXED, 2,   0, 1, make_rsp(0,   0, 0, STATUS_NO_INDEX, 1));
      add_row(OP_FREE,          0,  64, 1, make_rsp(64,  1, 0, STATUS_OK,       1));
      add_row(OP_ALLOC_INDEXED, 1,   0, 1, make_rsp(0,   0, 0, STATUS_SHORT,    1));
      add_row(OP_FREE,          0,  64, 0, '0);
      add_row(OP_ALLOC,         0, 127, 1, make_rsp(0,   0, 0, STATUS_OK,       1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         send_request(directed_plan[i].item, directed_plan[i].typed,
                      directed_plan[i].closing_rsp);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         item = draw_request();
         send_request(item, 1'b0, '0);
         if (item.operation != OP_UNUSED) random_sent++;
      end
      req_valid <= 1'b0;

      while (expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("block_bitmap_allocator_core: match");
      end else begin
         $display("block_bitmap_allocator_core: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
sv/bba_pkg.sv
sv/bba_bitmap_mem.sv
sv/bba_find_free.sv
sv/block_bitmap_allocator_core.sv
dv/tb_block_bitmap_allocator_core.sv
